### rtl/core/serial_frame_deframer_core_assert.svh
// Assertion macros for the deframer core
`ifndef SERIAL_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define SERIAL_FRAME_DEFRAMER_CORE_ASSERT_SVH
// implication checked every clock, held off in reset
`define SFD_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define SFD_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### rtl/core/sfd_pkg.sv
// ---------------------------------------------------------------------------
// sfd_pkg
// Types and constants shared by the deframer core.
// ---------------------------------------------------------------------------
package sfd_pkg;
    localparam int unsigned PAYLOAD_CAP = 10;
    localparam int unsigned MAX_RESULTS = 8;
    localparam int unsigned MIN_FRAME_BYTES = 4;

    typedef enum logic [1:0] {
        K_FRAME   = 2'd0,
        K_TIMEOUT = 2'd1,
        K_REBOOT  = 2'd2,
        K_OVERRUN = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_START = 2'd0,
        REG_MAXLEN = 2'd1,
        REG_WAIT = 2'd2,
        REG_HERR = 2'd3
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STORE,
        S_STEP,
        S_RD0,
        S_RD0W,
        S_RD2,
        S_RD2W,
        S_SUM,
        S_SUMW,
        S_CLEAR,
        S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       store;
        logic       rd_issue;
        logic [3:0] rd_off;
        logic       cap0;
        logic       cap2;
        logic       sum_clr;
        logic       sum_acc;
        logic       do_hunt;
        logic       do_start;
        logic       do_len;
        logic       do_wait;
        logic       do_sum;
        logic       do_clear;
        logic       tick_start;
        logic       out_pop;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       empty;
        logic [2:0] stage;
        logic [3:0] need_m1;
        logic       tick_done;
        logic       out_full;
        logic       pend;
        logic       out_valid;
    } t_sts;
endpackage

### rtl/core/sfd_if.sv
// ---------------------------------------------------------------------------
// sfd_in_if / sfd_out_if
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
interface sfd_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;
    modport source (output valid, mode, rx_byte, input ready);
    modport sink (input valid, mode, rx_byte, output ready);
endinterface

interface sfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  command;
    logic [3:0]  payload_len;
    logic [39:0] payload_low;
    logic [39:0] payload_high;
    logic        last_of_run;
    modport source (output valid, kind, command, payload_len, payload_low, payload_high,
                    last_of_run, input ready);
    modport sink (input valid, kind, command, payload_len, payload_low, payload_high,
                  last_of_run, output ready);
endinterface

### rtl/core/sfd_ram.sv
// ---------------------------------------------------------------------------
// sfd_ram
// Single-port write, single-port read RAM with registered read data.
// ---------------------------------------------------------------------------
module sfd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/sfd_ctrl.sv
// ---------------------------------------------------------------------------
// sfd_ctrl
// Sequencer: store a byte, or run parser steps over the ring on a tick.
// ---------------------------------------------------------------------------
module sfd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_mode,
    output logic          o_in_ready,
    input  sfd_pkg::t_sts i_sts,
    output sfd_pkg::t_cmd o_cmd
);
    import sfd_pkg::*;

    t_state r_state, n_state;
    logic [3:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k <= '0;
        end else begin
            r_state <= n_state;
            r_k <= n_k;
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && !i_sts.pend;

    always_comb begin
        n_state = r_state;
        n_k = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.pend) begin
                    n_state = S_OUT;
                end else if (i_in_valid) begin
                    if (!i_in_mode) begin
                        n_state = S_STORE;
                    end else if (!i_sts.empty) begin
                        n_state = S_STEP;
                    end
                end
            end
            S_STORE: n_state = i_sts.pend ? S_OUT : S_IDLE;
            S_STEP: begin
                if (i_sts.tick_done) begin
                    n_state = i_sts.pend ? S_OUT : S_IDLE;
                end else if (i_sts.out_full) begin
                    n_state = S_OUT;
                end else begin
                    unique case (i_sts.stage)
                        3'd1, 3'd2: n_state = S_RD0;
                        3'd3: n_state = S_RD2;
                        3'd4: begin
                            n_state = S_SUM;
                            n_k = '0;
                        end
                        default: n_state = S_STEP;
                    endcase
                end
            end
            S_RD0: n_state = S_RD0W;
            S_RD0W: n_state = S_RD2;
            S_RD2: n_state = S_RD2W;
            S_RD2W: n_state = S_STEP;
            S_SUM: n_state = S_SUMW;
            S_SUMW: begin
                if (r_k == i_sts.need_m1) begin
                    n_state = S_STEP;
                end else begin
                    n_k = r_k + 4'd1;
                    n_state = S_SUM;
                end
            end
            S_CLEAR: n_state = S_IDLE;
            S_OUT: begin
                if (!i_sts.out_valid) begin
                    if (!i_sts.tick_done) begin
                        n_state = S_STEP;
                    end else if (!i_sts.pend) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.rd_off = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (!i_sts.pend && i_in_valid) begin
                    o_cmd.store = !i_in_mode;
                    o_cmd.tick_start = i_in_mode && !i_sts.empty;
                end
            end
            S_STEP: begin
                if (!i_sts.tick_done && !i_sts.out_full) begin
                    unique case (i_sts.stage)
                        3'd1, 3'd2: begin
                            o_cmd.rd_issue = 1'b1;
                            o_cmd.rd_off = 4'd0;
                        end
                        3'd3: begin
                            o_cmd.rd_issue = 1'b1;
                            o_cmd.rd_off = 4'd2;
                        end
                        3'd4: o_cmd.sum_clr = 1'b1;
                        default: o_cmd.do_hunt = 1'b1;
                    endcase
                end
            end
            S_RD0: begin
                o_cmd.rd_issue = 1'b1;
                o_cmd.rd_off = 4'd2;
                o_cmd.cap0 = 1'b1;
            end
            S_RD0W: o_cmd.rd_off = 4'd2;
            S_RD2: o_cmd.rd_off = 4'd2;
            S_RD2W: begin
                o_cmd.cap2 = 1'b1;
                o_cmd.do_start = (i_sts.stage == 3'd1);
                o_cmd.do_len = (i_sts.stage == 3'd2);
                o_cmd.do_wait = (i_sts.stage == 3'd3);
            end
            S_SUM: o_cmd.rd_issue = 1'b1;
            S_SUMW: begin
                o_cmd.sum_acc = 1'b1;
                o_cmd.do_sum = (r_k == i_sts.need_m1);
            end
            S_OUT: o_cmd.out_pop = 1'b1;
            default: ;
        endcase
    end
endmodule

### rtl/core/sfd_dpath.sv
// ---------------------------------------------------------------------------
// sfd_dpath
// Ring store, pointers, counters, checksum and result register.
// ---------------------------------------------------------------------------
module sfd_dpath #(
    parameter int unsigned RING_DEPTH = 512,
    parameter int unsigned STEP_BUDGET = 30
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_rx_byte,
    input  logic [7:0]    i_start_code,
    input  logic [3:0]    i_max_len,
    input  logic [7:0]    i_wait_limit,
    input  logic [7:0]    i_herr_limit,
    input  sfd_pkg::t_cmd i_cmd,
    output sfd_pkg::t_sts o_sts,
    sfd_out_if.source     out_ch
);
    import sfd_pkg::*;

    localparam int unsigned AW = $clog2(RING_DEPTH);
    localparam int unsigned BW = $clog2(STEP_BUDGET + 1);

    logic [AW-1:0] r_rd, r_wr;
    logic [2:0]    r_stage;
    logic [7:0]    r_wait, r_serr, r_sum, r_b0;
    logic [3:0]    r_len;
    logic [BW-1:0] r_steps;
    logic [3:0]    r_nres;
    logic          r_done;
    logic [7:0]    r_cmdb;
    logic [79:0]   r_pay;
    logic [3:0]    r_roff;
    logic [7:0]    rdata;

    // pending result, held until the run shows whether another follows
    logic          r_pend;
    logic [1:0]    r_pkind;
    logic [7:0]    r_pcmd;
    logic [3:0]    r_plen;
    logic [79:0]   r_ppay;

    logic          r_ov;
    logic [1:0]    r_okind;
    logic [7:0]    r_ocmd;
    logic [3:0]    r_olen;
    logic [79:0]   r_opay;
    logic          r_olast;

    logic [AW-1:0] count;
    logic [3:0]    lim, len_c;
    logic [7:0]    b2;
    logic          step;

    assign count = r_wr - r_rd;
    assign lim = (i_max_len > 4'(PAYLOAD_CAP)) ? 4'(PAYLOAD_CAP) : i_max_len;
    assign b2 = rdata;
    assign len_c = (b2 > 8'(PAYLOAD_CAP)) ? 4'(PAYLOAD_CAP) : b2[3:0];
    assign step = i_cmd.do_hunt | i_cmd.do_start | i_cmd.do_len | i_cmd.do_wait
                | i_cmd.do_sum;

    sfd_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.store && (count != AW'(RING_DEPTH - 1))),
        .i_waddr(r_wr),
        .i_wdata(i_rx_byte),
        .i_raddr(r_rd + AW'(i_cmd.rd_off)),
        .o_rdata(rdata)
    );

    // outcome of this cycle's step
    logic          res_v, fin, flush, clr;
    logic [1:0]    res_k;
    logic [AW-1:0] adv;
    logic [2:0]    n_stage;
    logic [7:0]    n_wait, n_serr, sum_n;

    assign sum_n = r_sum + rdata;

    always_comb begin
        res_v = 1'b0;
        res_k = K_FRAME;
        fin = 1'b0;
        flush = 1'b0;
        clr = 1'b0;
        adv = '0;
        n_stage = r_stage;
        n_wait = r_wait;
        n_serr = r_serr;
        if (i_cmd.do_hunt) begin
            if (count < AW'(MIN_FRAME_BYTES)) begin
                n_stage = 3'd0;
                fin = 1'b1;
                if (r_wait >= i_wait_limit) begin
                    res_v = 1'b1;
                    res_k = K_TIMEOUT;
                    flush = 1'b1;
                    n_wait = '0;
                end else begin
                    n_wait = r_wait + 8'd1;
                end
            end else begin
                n_wait = '0;
                n_stage = 3'd1;
            end
        end
        if (i_cmd.do_start) begin
            if (r_b0 != i_start_code) begin
                if (r_serr >= i_herr_limit) begin
                    clr = 1'b1;
                    res_v = 1'b1;
                    res_k = K_REBOOT;
                    fin = 1'b1;
                end else begin
                    n_serr = r_serr + 8'd1;
                    adv = AW'(1);
                    n_stage = 3'd0;
                end
            end else begin
                n_stage = 3'd2;
            end
        end
        if (i_cmd.do_len) begin
            if (b2 > {4'd0, lim}) begin
                adv = AW'(1);
                n_stage = 3'd0;
                fin = 1'b1;
            end else begin
                n_stage = 3'd3;
            end
        end
        if (i_cmd.do_wait) begin
            if (count < AW'(len_c) + AW'(MIN_FRAME_BYTES)) begin
                fin = 1'b1;
                if (r_wait >= i_wait_limit) begin
                    res_v = 1'b1;
                    res_k = K_TIMEOUT;
                    flush = 1'b1;
                    n_wait = '0;
                    n_stage = 3'd0;
                end else begin
                    n_wait = r_wait + 8'd1;
                end
            end else begin
                n_wait = '0;
                n_stage = 3'd4;
            end
        end
        if (i_cmd.do_sum) begin
            n_stage = 3'd0;
            if (r_sum != rdata) begin
                adv = AW'(1);
                fin = 1'b1;
            end else begin
                res_v = 1'b1;
                res_k = K_FRAME;
                adv = AW'(r_len) + AW'(MIN_FRAME_BYTES);
                n_serr = '0;
            end
        end
    end

    logic [3:0] n_nres;
    logic       budget_out, n_done;
    assign n_nres = r_nres + 4'(res_v);
    assign budget_out = (r_steps + BW'(1)) >= BW'(STEP_BUDGET);
    assign n_done = fin | budget_out | (n_nres >= 4'(MAX_RESULTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
            r_wr <= '0;
            r_stage <= '0;
            r_wait <= '0;
            r_serr <= '0;
            r_sum <= '0;
            r_steps <= '0;
            r_nres <= '0;
            r_done <= 1'b1;
            r_pend <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_cmd.store) begin
                if (count == AW'(RING_DEPTH - 1)) begin
                    r_pend <= 1'b1;
                    r_pkind <= K_OVERRUN;
                    r_pcmd <= '0;
                    r_plen <= '0;
                    r_ppay <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_wr <= r_wr + AW'(1);
                end
            end
            if (i_cmd.tick_start) begin
                r_steps <= '0;
                r_nres <= '0;
                r_done <= 1'b0;
            end
            if (i_cmd.cap0) begin
                r_b0 <= rdata;
            end
            if (i_cmd.cap2) begin
                r_len <= len_c;
            end
            if (i_cmd.rd_issue) begin
                r_roff <= i_cmd.rd_off;
            end
            if (i_cmd.sum_clr) begin
                r_sum <= '0;
                r_pay <= '0;
            end
            if (i_cmd.sum_acc && !i_cmd.do_sum) begin
                r_sum <= sum_n;
                if (r_roff == 4'd1) begin
                    r_cmdb <= rdata;
                end
                if (r_roff >= 4'd3) begin
                    r_pay[8*(r_roff-4'd3) +: 8] <= rdata;
                end
            end
            if (step) begin
                if (clr) begin
                    r_rd <= '0;
                    r_wr <= '0;
                    r_stage <= '0;
                    r_wait <= '0;
                    r_serr <= '0;
                    r_sum <= '0;
                end else begin
                    r_stage <= n_stage;
                    r_wait <= n_wait;
                    r_serr <= n_serr;
                    r_rd <= flush ? r_wr : r_rd + adv;
                end
                r_steps <= r_steps + BW'(1);
                r_nres <= n_nres;
                r_done <= n_done;
                if (res_v) begin
                    r_pend <= 1'b1;
                    r_pkind <= res_k;
                    r_pcmd <= (res_k == K_FRAME) ? r_cmdb : 8'd0;
                    r_plen <= (res_k == K_FRAME) ? r_len : 4'd0;
                    r_ppay <= (res_k == K_FRAME) ? r_pay : 80'd0;
                end
            end
            // a newer result pushes the held one out as not last; at the end
            // of the run the held one goes out as last
            if (step && res_v && r_pend) begin
                r_ov <= 1'b1;
                r_okind <= r_pkind;
                r_ocmd <= r_pcmd;
                r_olen <= r_plen;
                r_opay <= r_ppay;
                r_olast <= 1'b0;
            end else if (i_cmd.out_pop && r_pend && r_done && (!r_ov || out_ch.ready)) begin
                r_ov <= 1'b1;
                r_okind <= r_pkind;
                r_ocmd <= r_pcmd;
                r_olen <= r_plen;
                r_opay <= r_ppay;
                r_olast <= r_done;
                r_pend <= 1'b0;
            end else if (r_ov && out_ch.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign out_ch.valid = r_ov;
    assign out_ch.kind = r_okind;
    assign out_ch.command = r_ocmd;
    assign out_ch.payload_len = r_olen;
    assign out_ch.payload_low = r_opay[39:0];
    assign out_ch.payload_high = r_opay[79:40];
    assign out_ch.last_of_run = r_olast;

    assign o_sts.empty = (count == '0);
    assign o_sts.stage = (r_stage > 3'd4) ? 3'd0 : r_stage;
    assign o_sts.need_m1 = r_len + 4'(MIN_FRAME_BYTES - 1);
    assign o_sts.tick_done = r_done;
    assign o_sts.out_full = r_pend && r_ov;
    assign o_sts.pend = r_pend;
    assign o_sts.out_valid = r_ov;
endmodule

### rtl/core/serial_frame_deframer_core.sv
// A stored byte is written to the ring before the next byte is taken; a parser step hunts,
// waits for the whole frame, checks start or length through ring reads, or runs a checksum pass.
// Each result is handed off through the output register; a tick holds the input until
// its run ends and its results are handed off.
// Reset: synchronous active-low i_rst_n clears pointers, counters and stage;
// the ring contents stay undefined until written; registers return to defaults.
// ---------------------------------------------------------------------------
// serial_frame_deframer_core
// Serial frame deframer with ring store, APB registers and result channel.
// ---------------------------------------------------------------------------
`include "serial_frame_deframer_core_assert.svh"
module serial_frame_deframer_core #(
    parameter int unsigned RING_DEPTH = 512,
    parameter int unsigned STEP_BUDGET = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    sfd_in_if.sink      in_ch,
    sfd_out_if.source   out_ch
);
    import sfd_pkg::*;

    logic [7:0] r_start, r_wlim, r_hlim;
    logic [3:0] r_maxl;
    t_cmd cmd;
    t_sts sts;
    logic wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 8'hF2;
            r_maxl <= 4'd10;
            r_wlim <= 8'd20;
            r_hlim <= 8'd20;
        end else if (wr && paddr[1:0] == 2'b00) begin
            unique case (t_reg'(paddr[3:2]))
                REG_START: r_start <= pwdata[7:0];
                REG_MAXLEN: r_maxl <= pwdata[3:0];
                REG_WAIT: r_wlim <= pwdata[7:0];
                REG_HERR: r_hlim <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[3:2]))
            REG_START: prdata = {24'd0, r_start};
            REG_MAXLEN: prdata = {28'd0, r_maxl};
            REG_WAIT: prdata = {24'd0, r_wlim};
            REG_HERR: prdata = {24'd0, r_hlim};
            default: prdata = '0;
        endcase
    end

    sfd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(in_ch.valid),
        .i_in_mode (in_ch.mode),
        .o_in_ready(in_ch.ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    sfd_dpath #(.RING_DEPTH(RING_DEPTH), .STEP_BUDGET(STEP_BUDGET)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_byte   (in_ch.rx_byte),
        .i_start_code(r_start),
        .i_max_len   (r_maxl),
        .i_wait_limit(r_wlim),
        .i_herr_limit(r_hlim),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .out_ch      (out_ch)
    );

    `SFD_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, in_ch.ready, !sts.pend)
    `SFD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
    `SFD_ASSERT_IMP(a_one_step, i_clk, i_rst_n, cmd.store, !cmd.do_hunt && !cmd.do_sum)
endmodule
